[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the search block
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define BFK_CHECK(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define BFK_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

[sv/bfknn_pkg.sv]
// ---------------------------------------------------------------------------
// bfknn_pkg
// constants, codes and controller/datapath types for the knn search block
// ---------------------------------------------------------------------------
package bfknn_pkg;

   // sizes
   localparam int CAPACITY = 1024;
   localparam int DIM_MAX  = 128;
   localparam int K_MAX    = 16;
   localparam int ELEM_W   = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DIM_AW   = $clog2(DIM_MAX);
   localparam int DIM_W    = 8;
   localparam int TOPK_W   = 5;
   localparam int KI_W     = $clog2(K_MAX);
   localparam int KN_W     = $clog2(K_MAX + 1);
   localparam int VADDR_W  = IDX_W + DIM_AW;
   localparam int SCORE_W  = 48;
   localparam int NORM_W   = 24;
   localparam int ROOT_W   = 20;
   localparam int SUMSQ_W  = 40;
   localparam int MAG_W    = 38;
   localparam int DEN_W    = 44;
   localparam int QUOT_W   = 15;
   localparam int STEP_W   = 5;
   localparam int CSR_IW   = 2;
   localparam int CSR_DW   = 8;

   localparam logic signed [SCORE_W-1:0] COS_MAX = 48'sd32767;
   localparam logic signed [SCORE_W-1:0] COS_MIN = -48'sd32768;

   // register indexes
   localparam logic [CSR_IW-1:0] REG_DIM    = 2'd0;
   localparam logic [CSR_IW-1:0] REG_TOPK   = 2'd1;
   localparam logic [CSR_IW-1:0] REG_METRIC = 2'd2;

   // request kinds and metrics
   localparam logic REQ_ADD    = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;
   localparam logic MET_L2     = 1'b0;
   localparam logic MET_COSINE = 1'b1;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_ZERO  = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic              metric;
      logic              elem_wr;
      logic              elem_last;
      logic [DIM_AW-1:0] elem_addr;
      logic [IDX_W-1:0]  slot;
      logic              slot_ok;
      logic              acc_clr;
      logic              iter_go;
      logic              iter_div;
      logic              qnorm_ld;
      logic              norm_wr;
      logic              vec_start;
      logic [IDX_W-1:0]  vidx;
      logic              rd_en;
      logic [DIM_AW-1:0] rd_j;
      logic              rd_last;
      logic              score_ld;
      logic              list_clr;
      logic              ins;
      logic [KN_W-1:0]   ins_lim;
      logic              emit;
      logic [KI_W-1:0]   emit_idx;
      logic              emit_last;
      logic              err;
      logic [1:0]        err_code;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic sum_zero;
      logic iter_done;
      logic acc_done;
      logic norm_zero;
      logic slot_free;
   } stat_type;

endpackage

[sv/bfknn_if.sv]
// ---------------------------------------------------------------------------
// bfknn channel interfaces
// request and response channels with valid/ready handshake
// ---------------------------------------------------------------------------
interface bfknn_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 req_type;
   logic signed [bfknn_pkg::ELEM_W-1:0]  elem_value;

   modport source (output valid, req_type, elem_value, input ready);
   modport sink   (input valid, req_type, elem_value, output ready);
endinterface

interface bfknn_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [bfknn_pkg::IDX_W-1:0]           result_index;
   logic signed [bfknn_pkg::SCORE_W-1:0]  result_value;
   logic                                  result_last;
   logic [1:0]                            status;

   modport source (output valid, result_index, result_value, result_last, status,
                   input ready);
   modport sink   (input valid, result_index, result_value, result_last, status,
                   output ready);
endinterface

[sv/bfknn_iter.sv]
// ---------------------------------------------------------------------------
// bfknn_iter
// shared iterative unit: integer square root (two bits a step) and
// fraction division (one quotient bit a step) with overflow flag
// ---------------------------------------------------------------------------
module bfknn_iter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             go,
   input  logic                             op_div,
   input  logic [bfknn_pkg::SUMSQ_W-1:0]    radicand,
   input  logic [bfknn_pkg::MAG_W-1:0]      dividend,
   input  logic [bfknn_pkg::DEN_W-1:0]      divisor,
   output logic                             done,
   output logic [bfknn_pkg::ROOT_W-1:0]     root,
   output logic [bfknn_pkg::QUOT_W-1:0]     quot,
   output logic                             ovf
);
   import bfknn_pkg::*;

   localparam int REM_W = DEN_W + 1;

   logic                busy_ff;
   logic                done_ff;
   logic                op_ff;
   logic                ovf_ff;
   logic [STEP_W-1:0]   cnt_ff;
   logic [REM_W-1:0]    rem_ff;
   logic [REM_W-1:0]    rem_in;
   logic [SUMSQ_W-1:0]  work_ff;
   logic [ROOT_W-1:0]   res_ff;
   logic [ROOT_W-1:0]   res_in;
   logic [DEN_W-1:0]    dvs_ff;
   logic [REM_W-1:0]    shifted;
   logic [REM_W-1:0]    trial;
   logic                take;

   // one step of the selected recurrence
   always_comb begin
      if (op_ff) begin
         shifted = {rem_ff[REM_W-2:0], 1'b0};
         trial   = {1'b0, dvs_ff};
      end else begin
         shifted = {rem_ff[REM_W-3:0], work_ff[SUMSQ_W-1 -: 2]};
         trial   = {{(REM_W-ROOT_W-2){1'b0}}, res_ff, 2'b01};
      end
      take   = shifted >= trial;
      rem_in = take ? shifted - trial : shifted;
      res_in = {res_ff[ROOT_W-2:0], take};
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // operands and partial results
   always_ff @(posedge clock) begin
      if (go) begin
         op_ff  <= op_div;
         res_ff <= '0;
         dvs_ff <= divisor;
         if (op_div) begin
            cnt_ff  <= STEP_W'(QUOT_W - 1);
            rem_ff  <= REM_W'(dividend);
            work_ff <= '0;
            ovf_ff  <= DEN_W'(dividend) >= divisor;
         end else begin
            cnt_ff  <= STEP_W'(ROOT_W - 1);
            rem_ff  <= '0;
            work_ff <= radicand;
            ovf_ff  <= 1'b0;
         end
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff - 1'b1;
         rem_ff  <= rem_in;
         res_ff  <= res_in;
         work_ff <= {work_ff[SUMSQ_W-3:0], 2'b00};
      end
   end

   assign done = done_ff;
   assign root = res_ff;
   assign quot = res_ff[QUOT_W-1:0];
   assign ovf  = ovf_ff;

endmodule

[sv/bfknn_dp.sv]
// ---------------------------------------------------------------------------
// bfknn_dp
// datapath: vector, norm and query memories, scoring pipeline, top-k list
// and the result register
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bfknn_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  bfknn_pkg::cmd_type                 cmd,
   output bfknn_pkg::stat_type                stat,
   input  logic signed [bfknn_pkg::ELEM_W-1:0] elem_value,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic [bfknn_pkg::IDX_W-1:0]        rsp_index,
   output logic signed [bfknn_pkg::SCORE_W-1:0] rsp_value,
   output logic                               rsp_last,
   output logic [1:0]                         rsp_status
);
   import bfknn_pkg::*;

   localparam int PROD_W = 35;

   // memories
   logic signed [ELEM_W-1:0] vmem [CAPACITY*DIM_MAX];
   logic [NORM_W-1:0]        nmem [CAPACITY];
   logic signed [ELEM_W-1:0] qmem [DIM_MAX];

   logic signed [ELEM_W-1:0] v_rd_ff;
   logic signed [ELEM_W-1:0] q_rd_ff;
   logic [NORM_W-1:0]        n_rd_ff;

   logic [SUMSQ_W-1:0]       nacc_ff;
   logic [SUMSQ_W-1:0]       nacc_in;
   logic [SUMSQ_W-1:0]       sumsq_ff;
   logic signed [2*ELEM_W-1:0] esq;
   logic [ROOT_W-1:0]        qnorm_ff;
   logic [DEN_W-1:0]         den_ff;

   logic                     rv_ff, rl_ff, pv_ff, pl_ff, done_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [ELEM_W:0]   diff;
   logic signed [2*ELEM_W+1:0] dsq;
   logic signed [2*ELEM_W-1:0] dprod;
   logic signed [SCORE_W-1:0] sum_ff;
   logic signed [SCORE_W-1:0] sum_abs;

   logic                     iter_done;
   logic [ROOT_W-1:0]        iter_root;
   logic [QUOT_W-1:0]        iter_quot;
   logic                     iter_ovf;

   logic signed [SCORE_W-1:0] div_score;
   logic signed [SCORE_W-1:0] score_in;
   logic signed [SCORE_W-1:0] s_ff;

   logic signed [SCORE_W-1:0] sc_ff  [K_MAX];
   logic [IDX_W-1:0]          ix_ff  [K_MAX];
   logic signed [SCORE_W-1:0] sc_up  [K_MAX];
   logic [IDX_W-1:0]          ix_up  [K_MAX];
   logic [K_MAX-1:0]          vld_ff;
   logic [K_MAX-1:0]          vld_prev;
   logic [K_MAX-1:0]          ins;
   logic [K_MAX-1:0]          ins_prev;

   logic                      rsp_valid_ff;
   logic                      slot_free;

   function automatic logic better(input logic met, input logic signed [SCORE_W-1:0] a,
                                   input logic signed [SCORE_W-1:0] b);
      return met ? (a > b) : (a < b);
   endfunction

   // element intake: store, query buffer, running sum of squares
   assign esq     = elem_value * elem_value;
   assign nacc_in = nacc_ff + SUMSQ_W'(unsigned'(esq));

   always_ff @(posedge clock) begin
      if (cmd.elem_wr && cmd.slot_ok) begin
         vmem[{cmd.slot, cmd.elem_addr}] <= elem_value;
      end
      v_rd_ff <= vmem[{cmd.vidx, cmd.rd_j}];
   end

   always_ff @(posedge clock) begin
      if (cmd.elem_wr) begin
         qmem[cmd.elem_addr] <= elem_value;
      end
      q_rd_ff <= qmem[cmd.rd_j];
   end

   always_ff @(posedge clock) begin
      if (cmd.norm_wr) begin
         nmem[cmd.slot] <= NORM_W'(iter_root);
      end
      n_rd_ff <= nmem[cmd.vidx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nacc_ff <= '0;
      end else if (cmd.acc_clr) begin
         nacc_ff <= '0;
      end else if (cmd.elem_wr) begin
         nacc_ff <= cmd.elem_last ? '0 : nacc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.elem_wr && cmd.elem_last) begin
         sumsq_ff <= nacc_in;
      end
      if (cmd.qnorm_ld) begin
         qnorm_ff <= iter_root;
      end
      den_ff <= DEN_W'(qnorm_ff) * DEN_W'(n_rd_ff);
   end

   // scoring pipeline: read, product, accumulate
   assign diff  = (ELEM_W+1)'(q_rd_ff) - (ELEM_W+1)'(v_rd_ff);
   assign dsq   = diff * diff;
   assign dprod = q_rd_ff * v_rd_ff;
   assign prod_in = (cmd.metric == MET_COSINE) ? PROD_W'(dprod) : PROD_W'(dsq);

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff   <= 1'b0;
         pv_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         rv_ff   <= cmd.rd_en;
         pv_ff   <= rv_ff;
         done_ff <= pv_ff && pl_ff;
      end
   end

   always_ff @(posedge clock) begin
      rl_ff   <= cmd.rd_last;
      pl_ff   <= rl_ff;
      prod_ff <= prod_in;
      if (cmd.vec_start) begin
         sum_ff <= '0;
      end else if (pv_ff) begin
         sum_ff <= sum_ff + SCORE_W'(prod_ff);
      end
   end

   assign sum_abs = sum_ff[SCORE_W-1] ? -sum_ff : sum_ff;

   bfknn_iter u_iter (
      .clock    (clock),
      .reset    (reset),
      .go       (cmd.iter_go),
      .op_div   (cmd.iter_div),
      .radicand (sumsq_ff),
      .dividend (sum_abs[MAG_W-1:0]),
      .divisor  (den_ff),
      .done     (iter_done),
      .root     (iter_root),
      .quot     (iter_quot),
      .ovf      (iter_ovf)
   );

   // final score of the current stored vector
   always_comb begin
      if (iter_ovf) begin
         div_score = sum_ff[SCORE_W-1] ? COS_MIN : COS_MAX;
      end else if (sum_ff[SCORE_W-1]) begin
         div_score = -$signed({{(SCORE_W-QUOT_W){1'b0}}, iter_quot});
      end else begin
         div_score = $signed({{(SCORE_W-QUOT_W){1'b0}}, iter_quot});
      end
      if (cmd.metric == MET_L2) begin
         score_in = sum_ff;
      end else if (n_rd_ff == '0) begin
         score_in = '0;
      end else begin
         score_in = div_score;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.score_ld) begin
         s_ff <= score_in;
      end
   end

   // sorted insertion: first slot the new score beats, rest shift down
   assign vld_prev = {vld_ff[K_MAX-2:0], 1'b1};

   always_comb begin
      for (int i = 0; i < K_MAX; i++) begin
         ins[i] = (KN_W'(i) < cmd.ins_lim) &&
                  (vld_ff[i] ? better(cmd.metric, s_ff, sc_ff[i]) : vld_prev[i]);
      end
      ins_prev = {ins[K_MAX-2:0], 1'b0};
      sc_up[0] = s_ff;
      ix_up[0] = cmd.vidx;
      for (int i = 1; i < K_MAX; i++) begin
         sc_up[i] = sc_ff[i-1];
         ix_up[i] = ix_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (cmd.list_clr) begin
         vld_ff <= '0;
      end else if (cmd.ins) begin
         vld_ff <= vld_ff | ins;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < K_MAX; i++) begin
         if (cmd.ins && ins[i]) begin
            sc_ff[i] <= ins_prev[i] ? sc_up[i] : s_ff;
            ix_ff[i] <= ins_prev[i] ? ix_up[i] : cmd.vidx;
         end
      end
   end

   // result register
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit || cmd.err) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_index  <= ix_ff[cmd.emit_idx];
         rsp_value  <= sc_ff[cmd.emit_idx];
         rsp_last   <= cmd.emit_last;
         rsp_status <= ST_OK;
      end else if (cmd.err) begin
         rsp_index  <= '0;
         rsp_value  <= '0;
         rsp_last   <= 1'b1;
         rsp_status <= cmd.err_code;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign stat.sum_zero  = nacc_in == '0;
   assign stat.iter_done = iter_done;
   assign stat.acc_done  = done_ff;
   assign stat.norm_zero = n_rd_ff == '0;
   assign stat.slot_free = slot_free;

   // checks
   `BFK_IMPLY(a_done_follows_read, clock, reset, done_ff,
              $past(cmd.rd_en && cmd.rd_last, 3), "score done without a last read")
   `BFK_IMPLY(a_ins_after_score, clock, reset, cmd.ins, $past(cmd.score_ld),
              "insert without a fresh score")
   `BFK_CHECK(a_list_packed, clock, reset, (vld_ff & (vld_ff + 1'b1)) == '0,
              "best list has a hole")

endmodule

[sv/bfknn_ctrl.sv]
// ---------------------------------------------------------------------------
// bfknn_ctrl
// controller: configuration registers, element and vector counters and the
// sequencer for add, query scan and result output
// ---------------------------------------------------------------------------
module bfknn_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [bfknn_pkg::CSR_IW-1:0]    csr_index,
   input  logic [bfknn_pkg::CSR_DW-1:0]    csr_data,
   input  logic                            req_valid,
   input  logic                            req_type,
   output logic                            req_ready,
   output bfknn_pkg::cmd_type              cmd,
   input  bfknn_pkg::stat_type             stat
);
   import bfknn_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_NSTART = 4'd1;
   localparam logic [3:0] S_NWAIT  = 4'd2;
   localparam logic [3:0] S_QSTART = 4'd3;
   localparam logic [3:0] S_QWAIT  = 4'd4;
   localparam logic [3:0] S_VSTART = 4'd5;
   localparam logic [3:0] S_VREAD  = 4'd6;
   localparam logic [3:0] S_VDRAIN = 4'd7;
   localparam logic [3:0] S_VDIV   = 4'd8;
   localparam logic [3:0] S_VINS   = 4'd9;
   localparam logic [3:0] S_EMIT   = 4'd10;

   logic [3:0]        state_ff, state_in;
   logic [DIM_W-1:0]  dim_ff, dim_in;
   logic [TOPK_W-1:0] topk_ff, topk_in;
   logic              metric_ff, metric_in;
   logic [CNT_W-1:0]  vcount_ff, vcount_in;
   logic [DIM_W-1:0]  ecnt_ff, ecnt_in;
   logic [DIM_AW-1:0] j_ff, j_in;
   logic [IDX_W-1:0]  vidx_ff, vidx_in;
   logic [KI_W-1:0]   oidx_ff, oidx_in;
   logic [KN_W-1:0]   n_ff, n_in;

   logic [DIM_W-1:0]  eff_d;
   logic [KN_W-1:0]   eff_k;
   logic [DIM_W-1:0]  cnt_eff;
   logic              el_last;
   logic              accept;
   logic              store_ok;
   logic              rd_last;
   logic              emit_last;

   // effective configuration
   always_comb begin
      if (dim_ff == '0) begin
         eff_d = DIM_W'(1);
      end else if (dim_ff > DIM_W'(DIM_MAX)) begin
         eff_d = DIM_W'(DIM_MAX);
      end else begin
         eff_d = dim_ff;
      end
      if (topk_ff == '0) begin
         eff_k = KN_W'(1);
      end else if (topk_ff > TOPK_W'(K_MAX)) begin
         eff_k = KN_W'(K_MAX);
      end else begin
         eff_k = KN_W'(topk_ff);
      end
   end

   assign req_ready = (state_ff == S_IDLE) && stat.slot_free;
   assign accept    = req_valid && req_ready;
   assign cnt_eff   = (ecnt_ff >= eff_d) ? '0 : ecnt_ff;
   assign el_last   = (cnt_eff + 1'b1) >= eff_d;
   assign store_ok  = vcount_ff < CNT_W'(CAPACITY);
   assign rd_last   = (DIM_W'(j_ff) + 1'b1) == eff_d;
   assign emit_last = (KN_W'(oidx_ff) + 1'b1) == n_ff;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      dim_in    = dim_ff;
      topk_in   = topk_ff;
      metric_in = metric_ff;
      vcount_in = vcount_ff;
      ecnt_in   = ecnt_ff;
      j_in      = j_ff;
      vidx_in   = vidx_ff;
      oidx_in   = oidx_ff;
      n_in      = n_ff;

      cmd           = '0;
      cmd.metric    = metric_ff;
      cmd.elem_addr = cnt_eff[DIM_AW-1:0];
      cmd.slot      = vcount_ff[IDX_W-1:0];
      cmd.slot_ok   = store_ok;
      cmd.vidx      = vidx_ff;
      cmd.rd_j      = j_ff;
      cmd.rd_last   = rd_last;
      cmd.ins_lim   = n_ff;
      cmd.emit_idx  = oidx_ff;
      cmd.emit_last = emit_last;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.elem_wr = 1'b1;
               if (!el_last) begin
                  ecnt_in = cnt_eff + 1'b1;
               end else begin
                  ecnt_in       = '0;
                  cmd.elem_last = 1'b1;
                  if (req_type == REQ_ADD) begin
                     if (!store_ok) begin
                        cmd.err      = 1'b1;
                        cmd.err_code = ST_FULL;
                     end else begin
                        state_in = S_NSTART;
                     end
                  end else if (vcount_ff == '0) begin
                     cmd.err      = 1'b1;
                     cmd.err_code = ST_EMPTY;
                  end else if (metric_ff == MET_COSINE && stat.sum_zero) begin
                     cmd.err      = 1'b1;
                     cmd.err_code = ST_ZERO;
                  end else begin
                     n_in     = (CNT_W'(eff_k) < vcount_ff) ? eff_k : KN_W'(vcount_ff);
                     state_in = S_QSTART;
                  end
               end
            end
         end
         S_NSTART: begin
            cmd.iter_go = 1'b1;
            state_in    = S_NWAIT;
         end
         S_NWAIT: begin
            if (stat.iter_done) begin
               cmd.norm_wr = 1'b1;
               vcount_in   = vcount_ff + 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_QSTART: begin
            cmd.iter_go = 1'b1;
            state_in    = S_QWAIT;
         end
         S_QWAIT: begin
            if (stat.iter_done) begin
               cmd.qnorm_ld = 1'b1;
               cmd.list_clr = 1'b1;
               vidx_in      = '0;
               state_in     = S_VSTART;
            end
         end
         S_VSTART: begin
            cmd.vec_start = 1'b1;
            j_in          = '0;
            state_in      = S_VREAD;
         end
         S_VREAD: begin
            cmd.rd_en = 1'b1;
            j_in      = j_ff + 1'b1;
            if (rd_last) begin
               state_in = S_VDRAIN;
            end
         end
         S_VDRAIN: begin
            if (stat.acc_done) begin
               if (metric_ff == MET_COSINE && !stat.norm_zero) begin
                  cmd.iter_go  = 1'b1;
                  cmd.iter_div = 1'b1;
                  state_in     = S_VDIV;
               end else begin
                  cmd.score_ld = 1'b1;
                  state_in     = S_VINS;
               end
            end
         end
         S_VDIV: begin
            if (stat.iter_done) begin
               cmd.score_ld = 1'b1;
               state_in     = S_VINS;
            end
         end
         S_VINS: begin
            cmd.ins = 1'b1;
            if ((CNT_W'(vidx_ff) + 1'b1) == vcount_ff) begin
               oidx_in  = '0;
               state_in = S_EMIT;
            end else begin
               vidx_in  = vidx_ff + 1'b1;
               state_in = S_VSTART;
            end
         end
         S_EMIT: begin
            if (stat.slot_free) begin
               cmd.emit = 1'b1;
               if (emit_last) begin
                  state_in = S_IDLE;
               end else begin
                  oidx_in = oidx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // register writes, to be made only while idle; the block itself does not enforce this
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_DIM: begin
               dim_in      = csr_data;
               ecnt_in     = '0;
               cmd.acc_clr = 1'b1;
            end
            REG_TOPK: begin
               topk_in = csr_data[TOPK_W-1:0];
            end
            REG_METRIC: begin
               metric_in = csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         dim_ff    <= DIM_W'(1);
         topk_ff   <= TOPK_W'(1);
         metric_ff <= MET_L2;
         vcount_ff <= '0;
         ecnt_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         dim_ff    <= dim_in;
         topk_ff   <= topk_in;
         metric_ff <= metric_in;
         vcount_ff <= vcount_in;
         ecnt_ff   <= ecnt_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff    <= j_in;
      vidx_ff <= vidx_in;
      oidx_ff <= oidx_in;
      n_ff    <= n_in;
   end

endmodule

[sv/brute_force_knn_search.sv]
// ---------------------------------------------------------------------------
// brute_force_knn_search
// vector store with exhaustive top-k nearest neighbour search
// ---------------------------------------------------------------------------
// Usage: items on req_if carry one Q8.8 element each; dim elements make a
// vector, and the kind of the final element decides add or query. csr_* sets
// dim, top_k and metric while the block is idle.
// An element that does not complete a vector leaves the block idle for the next.
// A completed add then computes the norm with the 20-step square root.
// A query first computes its own norm, then for each stored vector reads
// dim elements (squared L2), plus the 15-step divider for cosine;
// the element loop runs over the vector memory read port.
// Results leave rsp_if at one item per cycle unless stalled, the last marked;
// errors give a single marked item with a status code.
// Reset empties the store and sets dim 1, top_k 1, squared L2; the memories
// are not cleared. A stalled receiver holds the result register and the
// block waits; req_if is not ready while work runs or a result is stalled.
// ---------------------------------------------------------------------------
module brute_force_knn_search (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [bfknn_pkg::CSR_IW-1:0]  csr_index,
   input  logic [bfknn_pkg::CSR_DW-1:0]  csr_data,
   bfknn_req_if.sink                     req_if,
   bfknn_rsp_if.source                   rsp_if
);
   import bfknn_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;

   bfknn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_valid (req_if.valid),
      .req_type  (req_if.req_type),
      .req_ready (req_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   bfknn_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .elem_value (req_if.elem_value),
      .rsp_ready  (rsp_if.ready),
      .rsp_valid  (rsp_if.valid),
      .rsp_index  (rsp_if.result_index),
      .rsp_value  (rsp_if.result_value),
      .rsp_last   (rsp_if.result_last),
      .rsp_status (rsp_if.status)
   );

   assign req_if.ready = req_ready;

endmodule
